### rtl/lr_pkg.sv
// Package for the line rasterizer: coordinate widths, payload types and codes.
// No dependencies; every other file in rtl/ uses it.
package lr_pkg;

  localparam int COORD_BITS = 16;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SPAN_BITS-1:0]  span_t;
  typedef logic        [COORD_BITS-1:0] len_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_REJECT = 2'd1,
    ST_IDLE   = 2'd2
  } status_t;

endpackage

### rtl/lr_ifs.sv
// Valid/ready channel interfaces for the line rasterizer: command in, pixel out.
// Depends on lr_pkg for the payload types.
interface lr_cmd_if;
  logic              valid;
  logic              ready;
  lr_pkg::op_t       operation;
  lr_pkg::coord_t    x_start;
  lr_pkg::coord_t    y_start;
  lr_pkg::coord_t    x_end;
  lr_pkg::coord_t    y_end;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lr_pixel_if;
  logic              valid;
  logic              ready;
  lr_pkg::coord_t    point_x;
  lr_pkg::coord_t    point_y;
  lr_pkg::status_t   status;
  logic              last_point;

  modport source (output valid, point_x, point_y, status, last_point, input ready);
  modport sink   (input valid, point_x, point_y, status, last_point, output ready);
endinterface

### rtl/line_rasterizer_core.sv
// Line rasterizer top level: start/advance commands in, one pixel transaction out per command.
// Depends on lr_pkg and the channel interfaces in lr_ifs.sv.
//
//   channel  dir  payload
//   cmd      in   operation, x_start, y_start, x_end, y_end
//   pixel    out  point_x, point_y, status, last_point
//
// Every command is answered in the cycle after its transaction, and one command per cycle is
// sustained while the pixel output is not stalled. The rounding error is kept as a running term
// updated by one add and compare per pixel. A stalled pixel output holds its register and
// blocks the command side. Reset is synchronous and leaves no line active.
module line_rasterizer_core (
  input logic       clk,
  input logic       rst,
  lr_cmd_if.sink    cmd,
  lr_pixel_if.source pixel
);
  import lr_pkg::*;

  logic    active, active_next;
  logic    steep, steep_next;
  coord_t  cur_x, cur_x_next, cur_y, cur_y_next;
  coord_t  tgt_x, tgt_x_next, tgt_y, tgt_y_next;
  span_t   span_x, span_x_next, span_y, span_y_next;
  len_t    major, major_next;
  len_t    idx, idx_next;
  err_t    err, err_next;

  logic    out_valid;
  coord_t  res_x, res_x_next, res_y, res_y_next;
  status_t res_status, res_status_next;
  logic    res_last, res_last_next;

  logic    accept;
  span_t   in_span_x, in_span_y, minor_span;
  len_t    abs_x, abs_y;
  err_t    e, e_mag;
  logic    minor_step;
  coord_t  step_x, step_y;

  assign cmd.ready = !out_valid || pixel.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign in_span_x = span_t'(cmd.x_end) - span_t'(cmd.x_start);
  assign in_span_y = span_t'(cmd.y_end) - span_t'(cmd.y_start);
  assign abs_x     = len_t'(in_span_x[SPAN_BITS-1] ? -in_span_x : in_span_x);
  assign abs_y     = len_t'(in_span_y[SPAN_BITS-1] ? -in_span_y : in_span_y);

  assign minor_span = steep ? span_x : span_y;
  assign e          = err + err_t'(minor_span);
  assign e_mag      = e[ERR_BITS-1] ? -e : e;
  assign minor_step = {e_mag, 1'b0} >= (ERR_BITS+1)'(major);
  assign step_x     = span_x[SPAN_BITS-1] ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
  assign step_y     = span_y[SPAN_BITS-1] ? cur_y - coord_t'(1) : cur_y + coord_t'(1);

  always_comb begin
    active_next     = active;
    steep_next      = steep;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    tgt_x_next      = tgt_x;
    tgt_y_next      = tgt_y;
    span_x_next     = span_x;
    span_y_next     = span_y;
    major_next      = major;
    idx_next        = idx;
    err_next        = err;
    res_x_next      = '0;
    res_y_next      = '0;
    res_status_next = ST_PIXEL;
    res_last_next   = 1'b0;
    unique case (cmd.operation)
      OP_START: begin
        if (cmd.x_start == cmd.x_end && cmd.y_start == cmd.y_end) begin
          active_next     = 1'b0;
          res_status_next = ST_REJECT;
        end else begin
          active_next = 1'b1;
          steep_next  = abs_y > abs_x;
          major_next  = (abs_y > abs_x) ? abs_y : abs_x;
          cur_x_next  = cmd.x_start;
          cur_y_next  = cmd.y_start;
          tgt_x_next  = cmd.x_end;
          tgt_y_next  = cmd.y_end;
          span_x_next = in_span_x;
          span_y_next = in_span_y;
          idx_next    = '0;
          err_next    = '0;
          res_x_next  = cmd.x_start;
          res_y_next  = cmd.y_start;
        end
      end
      OP_ADVANCE: begin
        if (!active) begin
          res_status_next = ST_IDLE;
        end else if (idx + len_t'(1) >= major) begin
          active_next   = 1'b0;
          idx_next      = idx + len_t'(1);
          cur_x_next    = tgt_x;
          cur_y_next    = tgt_y;
          res_x_next    = tgt_x;
          res_y_next    = tgt_y;
          res_last_next = 1'b1;
        end else begin
          idx_next = idx + len_t'(1);
          if (minor_step) begin
            err_next = minor_span[SPAN_BITS-1] ? e + err_t'(major) : e - err_t'(major);
          end else begin
            err_next = e;
          end
          if (steep) begin
            cur_y_next = step_y;
            cur_x_next = minor_step ? step_x : cur_x;
          end else begin
            cur_x_next = step_x;
            cur_y_next = minor_step ? step_y : cur_y;
          end
          res_x_next = steep ? (minor_step ? step_x : cur_x) : step_x;
          res_y_next = steep ? step_y : (minor_step ? step_y : cur_y);
        end
      end
      default: begin
        res_status_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        active    <= active_next;
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      steep      <= steep_next;
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      tgt_x      <= tgt_x_next;
      tgt_y      <= tgt_y_next;
      span_x     <= span_x_next;
      span_y     <= span_y_next;
      major      <= major_next;
      idx        <= idx_next;
      err        <= err_next;
      res_x      <= res_x_next;
      res_y      <= res_y_next;
      res_status <= res_status_next;
      res_last   <= res_last_next;
    end
  end

  assign pixel.valid      = out_valid;
  assign pixel.point_x    = res_x;
  assign pixel.point_y    = res_y;
  assign pixel.status     = res_status;
  assign pixel.last_point = res_last;

endmodule

### rtl/lr_checker.sv
// Port-level checker for line_rasterizer_core, attached by the bind statement below.
// Depends on lr_pkg for the status codes.
module lr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lr_pkg::coord_t  point_x,
  input lr_pkg::coord_t  point_y,
  input lr_pkg::status_t status,
  input logic            last_point
);
  import lr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel output valid right after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted command produced no pixel transaction");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("command taken while a pixel was stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(point_x) && $stable(point_y)
      && $stable(status) && $stable(last_point)))
    else $error("stalled pixel changed");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PIXEL) |-> (point_x == '0 && point_y == '0 && !last_point))
    else $error("non-pixel status carried coordinates or last flag");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd.valid),
  .in_ready   (cmd.ready),
  .out_valid  (pixel.valid),
  .out_ready  (pixel.ready),
  .point_x    (pixel.point_x),
  .point_y    (pixel.point_y),
  .status     (pixel.status),
  .last_point (pixel.last_point)
);
